[hw/rtl/dda_pkg.sv]
// Shared constants, codes and types of the DDA line rasterizer.
`default_nettype none

package dda_pkg;

  localparam int unsigned DEF_COORD_BITS = 16;
  localparam int unsigned DEF_FRAC_BITS  = 16;
  localparam int unsigned DEF_ADDR_BITS  = 24;

  localparam int unsigned CFG_BITS    = 13;
  localparam int unsigned COLOR_BITS  = 32;
  localparam int unsigned STATUS_BITS = 2;

  localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 13'd480;

  typedef enum logic [STATUS_BITS-1:0] {
    STATUS_WRITE = 2'd0,
    STATUS_CLIP  = 2'd1,
    STATUS_IDLE  = 2'd2
  } status_e;

  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_e;

  typedef enum logic {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

[hw/rtl/dda_div.sv]
// Serial restoring divider for the fixed-point DDA increments, one quotient bit a cycle.
`default_nettype none

module dda_div #(
  parameter int unsigned COORD_BITS = dda_pkg::DEF_COORD_BITS,
  parameter int unsigned FRAC_BITS  = dda_pkg::DEF_FRAC_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [COORD_BITS-1:0] dividend_i,
  input  wire logic [COORD_BITS-1:0] divisor_i,
  output      logic [FRAC_BITS:0]    quotient_o,
  output      dda_pkg::div_stat_t    stat_o
);

  localparam int unsigned REM_BITS = COORD_BITS + 1;
  localparam int unsigned CNT_BITS = $clog2(FRAC_BITS + 1);

  logic [REM_BITS-1:0]   rem_q;
  logic [COORD_BITS-1:0] div_q;
  logic [FRAC_BITS:0]    quo_q;
  logic [CNT_BITS-1:0]   cnt_q;
  logic                  busy_q;
  logic                  done_q;

  logic [REM_BITS-1:0]   trial;
  logic [REM_BITS-1:0]   diff;
  logic                  take;

  // integer bit first without a shift, then one fraction bit per cycle
  assign trial = (cnt_q == CNT_BITS'(FRAC_BITS)) ? rem_q : {rem_q[REM_BITS-2:0], 1'b0};
  assign take  = trial >= {1'b0, div_q};
  assign diff  = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      div_q  <= '0;
      quo_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      rem_q  <= {1'b0, dividend_i};
      div_q  <= divisor_i;
      quo_q  <= '0;
      cnt_q  <= CNT_BITS'(FRAC_BITS);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      rem_q  <= take ? diff : trial;
      quo_q  <= {quo_q[FRAC_BITS-1:0], take};
      cnt_q  <= cnt_q - CNT_BITS'(1);
      busy_q <= (cnt_q != '0);
      done_q <= (cnt_q == '0);
    end else begin
      done_q <= 1'b0;
    end
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

`default_nettype wire

[hw/rtl/dda_line_rasterizer.sv]
// Top level of the DDA line rasterizer: sequencer, position accumulators and pixel output.
//
//   channel   direction  handshake                  payload
//   input     in         in_valid_i / in_stall_o    operation, endpoints, line_color
//   output    out        out_valid_o / out_stall_i  pixel_address, pixel_color, status, last_pixel
//   config    in         cfg_we_i                   cfg_index_i, cfg_data_i
//
// An advance word or the start of a zero-length line goes through accept, pixel
// coordinate and clip, and address multiply, in that order.
// A start word of a nonzero line first waits on the shared serial divider that
// forms the x and then the y increment, one quotient bit a cycle.
// Reset restores the frame size to 640 by 480 and drops any line in progress.
// A stalled output word holds the sequencer in its last cycle; a new input word is
// taken only once the previous one has reached the output register.
`default_nettype none

module dda_line_rasterizer #(
  parameter int unsigned COORD_BITS = dda_pkg::DEF_COORD_BITS,
  parameter int unsigned FRAC_BITS  = dda_pkg::DEF_FRAC_BITS,
  parameter int unsigned ADDR_BITS  = dda_pkg::DEF_ADDR_BITS
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,

  input  wire logic                                cfg_we_i,
  input  wire logic                                cfg_index_i,
  input  wire logic [dda_pkg::CFG_BITS-1:0]        cfg_data_i,

  input  wire logic                                in_valid_i,
  output      logic                                in_stall_o,
  input  wire logic                                operation_i,
  input  wire logic signed [COORD_BITS-1:0]        x_start_i,
  input  wire logic signed [COORD_BITS-1:0]        y_start_i,
  input  wire logic signed [COORD_BITS-1:0]        x_end_i,
  input  wire logic signed [COORD_BITS-1:0]        y_end_i,
  input  wire logic [dda_pkg::COLOR_BITS-1:0]      line_color_i,

  output      logic                                out_valid_o,
  input  wire logic                                out_stall_i,
  output      logic [ADDR_BITS-1:0]                pixel_address_o,
  output      logic [dda_pkg::COLOR_BITS-1:0]      pixel_color_o,
  output      logic [dda_pkg::STATUS_BITS-1:0]     status_o,
  output      logic                                last_pixel_o
);

  localparam int unsigned CFGW      = dda_pkg::CFG_BITS;
  localparam int unsigned COLW      = dda_pkg::COLOR_BITS;
  localparam int unsigned POS_BITS  = COORD_BITS + FRAC_BITS;
  localparam int unsigned STEP_BITS = FRAC_BITS + 2;
  localparam int unsigned CMP_BITS  = (COORD_BITS > CFGW) ? COORD_BITS : CFGW;
  localparam int unsigned MUL_BITS  = (ADDR_BITS > 2 * CFGW + 1) ? ADDR_BITS : 2 * CFGW + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIVX,
    S_DIVY,
    S_PIX,
    S_OUT
  } state_e;

  state_e                       state_q;

  logic [CFGW-1:0]              frame_width_q;
  logic [CFGW-1:0]              frame_height_q;

  logic signed [POS_BITS-1:0]   pos_x_q;
  logic signed [POS_BITS-1:0]   pos_y_q;
  logic signed [STEP_BITS-1:0]  step_x_q;
  logic signed [STEP_BITS-1:0]  step_y_q;
  logic [COORD_BITS-1:0]        left_q;
  logic [COLW-1:0]              color_q;
  logic                         active_q;
  logic [COORD_BITS-1:0]        ax_q;
  logic [COORD_BITS-1:0]        ay_q;
  logic [COORD_BITS-1:0]        steps_q;
  logic                         negx_q;
  logic                         negy_q;
  logic                         last_q;
  logic                         idle_q;
  logic                         inside_q;
  logic [CFGW-1:0]              row_q;
  logic [CFGW-1:0]              col_q;
  logic                         div_start_q;

  logic                         out_valid_q;
  logic [ADDR_BITS-1:0]         addr_q;
  logic [COLW-1:0]              out_color_q;
  dda_pkg::status_e             status_q;
  logic                         out_last_q;

  logic                         in_accept;
  logic signed [COORD_BITS:0]   dx_s;
  logic signed [COORD_BITS:0]   dy_s;
  logic [COORD_BITS:0]          ndx;
  logic [COORD_BITS:0]          ndy;
  logic [COORD_BITS-1:0]        ax;
  logic [COORD_BITS-1:0]        ay;
  logic [COORD_BITS-1:0]        steps;

  logic [FRAC_BITS:0]           quo;
  dda_pkg::div_stat_t           div_stat;
  logic signed [STEP_BITS-1:0]  quo_s;
  logic signed [STEP_BITS-1:0]  step_new;

  logic signed [COORD_BITS-1:0] tx;
  logic signed [COORD_BITS-1:0] ty;
  logic [CMP_BITS-1:0]          tx_u;
  logic [CMP_BITS-1:0]          ty_u;
  logic                         inside_d;
  logic [CFGW-1:0]              row_d;
  logic [MUL_BITS-1:0]          addr_full;
  logic                         out_free;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    dx_s  = (COORD_BITS+1)'(x_end_i) - (COORD_BITS+1)'(x_start_i);
    dy_s  = (COORD_BITS+1)'(y_end_i) - (COORD_BITS+1)'(y_start_i);
    ndx   = -dx_s;
    ndy   = -dy_s;
    ax    = dx_s[COORD_BITS] ? ndx[COORD_BITS-1:0] : dx_s[COORD_BITS-1:0];
    ay    = dy_s[COORD_BITS] ? ndy[COORD_BITS-1:0] : dy_s[COORD_BITS-1:0];
    steps = (ax > ay) ? ax : ay;
  end

  dda_div #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start_q),
    .dividend_i((state_q == S_DIVY) ? ay_q : ax_q),
    .divisor_i (steps_q),
    .quotient_o(quo),
    .stat_o    (div_stat)
  );

  always_comb begin
    quo_s    = $signed({1'b0, quo});
    step_new = ((state_q == S_DIVY) ? negy_q : negx_q) ? -quo_s : quo_s;
  end

  // truncate toward zero, then clip against the frame
  always_comb begin
    tx = $signed(pos_x_q[POS_BITS-1:FRAC_BITS]) +
         COORD_BITS'(pos_x_q[POS_BITS-1] && (|pos_x_q[FRAC_BITS-1:0]));
    ty = $signed(pos_y_q[POS_BITS-1:FRAC_BITS]) +
         COORD_BITS'(pos_y_q[POS_BITS-1] && (|pos_y_q[FRAC_BITS-1:0]));
    tx_u = CMP_BITS'($unsigned(tx));
    ty_u = CMP_BITS'($unsigned(ty));
    inside_d = !tx[COORD_BITS-1] && !ty[COORD_BITS-1] &&
               (tx_u < CMP_BITS'(frame_width_q)) && (ty_u < CMP_BITS'(frame_height_q));
    row_d = frame_height_q - CFGW'(ty_u) - CFGW'(1);
  end

  assign addr_full = MUL_BITS'(row_q) * MUL_BITS'(frame_width_q) + MUL_BITS'(col_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      frame_width_q  <= dda_pkg::WIDTH_RESET;
      frame_height_q <= dda_pkg::HEIGHT_RESET;
      pos_x_q        <= '0;
      pos_y_q        <= '0;
      step_x_q       <= '0;
      step_y_q       <= '0;
      left_q         <= '0;
      color_q        <= '0;
      active_q       <= 1'b0;
      ax_q           <= '0;
      ay_q           <= '0;
      steps_q        <= '0;
      negx_q         <= 1'b0;
      negy_q         <= 1'b0;
      last_q         <= 1'b0;
      idle_q         <= 1'b0;
      inside_q       <= 1'b0;
      row_q          <= '0;
      col_q          <= '0;
      div_start_q    <= 1'b0;
      out_valid_q    <= 1'b0;
      addr_q         <= '0;
      out_color_q    <= '0;
      status_q       <= dda_pkg::STATUS_IDLE;
      out_last_q     <= 1'b0;
    end else begin
      div_start_q <= 1'b0;

      if (cfg_we_i) begin
        case (cfg_index_i)
          dda_pkg::CFG_WIDTH:  frame_width_q  <= cfg_data_i;
          dda_pkg::CFG_HEIGHT: frame_height_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (out_valid_q && !out_stall_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            if (operation_i == dda_pkg::OP_START) begin
              pos_x_q  <= {x_start_i, {FRAC_BITS{1'b0}}};
              pos_y_q  <= {y_start_i, {FRAC_BITS{1'b0}}};
              color_q  <= line_color_i;
              left_q   <= steps;
              steps_q  <= steps;
              ax_q     <= ax;
              ay_q     <= ay;
              negx_q   <= dx_s[COORD_BITS];
              negy_q   <= dy_s[COORD_BITS];
              active_q <= (steps != '0);
              last_q   <= (steps == '0);
              idle_q   <= 1'b0;
              if (steps == '0) begin
                step_x_q <= '0;
                step_y_q <= '0;
                state_q  <= S_PIX;
              end else begin
                div_start_q <= 1'b1;
                state_q     <= S_DIVX;
              end
            end else if (active_q) begin
              pos_x_q  <= pos_x_q + POS_BITS'(step_x_q);
              pos_y_q  <= pos_y_q + POS_BITS'(step_y_q);
              left_q   <= left_q - COORD_BITS'(1);
              last_q   <= (left_q == COORD_BITS'(1));
              active_q <= (left_q != COORD_BITS'(1));
              idle_q   <= 1'b0;
              state_q  <= S_PIX;
            end else begin
              idle_q  <= 1'b1;
              state_q <= S_PIX;
            end
          end
        end
        S_DIVX: begin
          if (div_stat.done) begin
            step_x_q    <= step_new;
            div_start_q <= 1'b1;
            state_q     <= S_DIVY;
          end
        end
        S_DIVY: begin
          if (div_stat.done) begin
            step_y_q <= step_new;
            state_q  <= S_PIX;
          end
        end
        S_PIX: begin
          inside_q <= inside_d;
          row_q    <= row_d;
          col_q    <= CFGW'(tx_u);
          state_q  <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            if (idle_q) begin
              status_q    <= dda_pkg::STATUS_IDLE;
              addr_q      <= '0;
              out_color_q <= '0;
              out_last_q  <= 1'b0;
            end else begin
              status_q    <= inside_q ? dda_pkg::STATUS_WRITE : dda_pkg::STATUS_CLIP;
              addr_q      <= inside_q ? ADDR_BITS'(addr_full) : '0;
              out_color_q <= color_q;
              out_last_q  <= last_q;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pixel_address_o = addr_q;
  assign pixel_color_o   = out_color_q;
  assign status_o        = status_q;
  assign last_pixel_o    = out_last_q;

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == S_DIVX || state_q == S_DIVY))
    else $error("divider finished outside a divide state");

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("output word loaded outside the output state");

  a_active_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (left_q != '0))
    else $error("line active with no pixels left");

  a_idle_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == dda_pkg::STATUS_IDLE) |->
      (out_color_q == '0 && !out_last_q && addr_q == '0))
    else $error("idle word carries pixel data");

endmodule

`default_nettype wire

[sim/testbench.sv]
// Self-checking testbench of the DDA line rasterizer: predicted pixel words against the output.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned COORD_W     = dda_pkg::DEF_COORD_BITS;
  localparam int unsigned FRAC_W      = dda_pkg::DEF_FRAC_BITS;
  localparam int unsigned ADDR_W      = dda_pkg::DEF_ADDR_BITS;
  localparam int unsigned DRAIN_WAIT  = 2 * FRAC_W + 24;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    logic [ADDR_W-1:0]              addr;
    logic [dda_pkg::COLOR_BITS-1:0] color;
    dda_pkg::status_e               status;
    logic                           last;
  } pixel_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we = 1'b0;
  logic                            cfg_index = dda_pkg::CFG_WIDTH;
  logic [dda_pkg::CFG_BITS-1:0]    cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic                            operation = dda_pkg::OP_START;
  logic signed [COORD_W-1:0]       x_start = '0;
  logic signed [COORD_W-1:0]       y_start = '0;
  logic signed [COORD_W-1:0]       x_end = '0;
  logic signed [COORD_W-1:0]       y_end = '0;
  logic [dda_pkg::COLOR_BITS-1:0]  line_color = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [ADDR_W-1:0]               pixel_address;
  logic [dda_pkg::COLOR_BITS-1:0]  pixel_color;
  logic [dda_pkg::STATUS_BITS-1:0] status;
  logic                            last_pixel;

  longint                         frame_w = dda_pkg::WIDTH_RESET;
  longint                         frame_h = dda_pkg::HEIGHT_RESET;
  longint                         cur_x = 0;
  longint                         cur_y = 0;
  longint                         inc_x = 0;
  longint                         inc_y = 0;
  longint                         pixels_remaining = 0;
  logic [dda_pkg::COLOR_BITS-1:0] held_color = '0;
  bit                             drawing = 1'b0;

  pixel_t      pixel_q[$];
  pixel_t      want;
  int unsigned sent_words = 0;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 36;
  int unsigned stall_pct = 61;

  dda_line_rasterizer u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .operation_i     (operation),
    .x_start_i       (x_start),
    .y_start_i       (y_start),
    .x_end_i         (x_end),
    .y_end_i         (y_end),
    .line_color_i    (line_color),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .pixel_address_o (pixel_address),
    .pixel_color_o   (pixel_color),
    .status_o        (status),
    .last_pixel_o    (last_pixel)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic longint line_steps(input logic signed [COORD_W-1:0] xs, ys, xe, ye);
    longint dx;
    longint dy;
    dx = longint'(xe) - longint'(xs);
    dy = longint'(ye) - longint'(ys);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return (dx > dy) ? dx : dy;
  endfunction

  function automatic longint fixed_ratio(input longint d, input longint steps);
    longint q;
    if (steps <= 0) return 0;
    q = ((d < 0 ? -d : d) << FRAC_W) / steps;
    return (d < 0) ? -q : q;
  endfunction

  function automatic longint pixel_coord(input longint p);
    return (p < 0) ? -((-p) >> FRAC_W) : (p >> FRAC_W);
  endfunction

  function automatic void push_pixel(input bit last);
    pixel_t px;
    longint col;
    longint row;
    col = pixel_coord(cur_x);
    row = pixel_coord(cur_y);
    px.color = held_color;
    px.last  = last;
    if (col >= 0 && col < frame_w && row >= 0 && row < frame_h) begin
      px.addr   = ADDR_W'((frame_h - 1 - row) * frame_w + col);
      px.status = dda_pkg::STATUS_WRITE;
    end else begin
      px.addr   = '0;
      px.status = dda_pkg::STATUS_CLIP;
    end
    pixel_q.push_back(px);
  endfunction

  function automatic void predict_pixel(input dda_pkg::op_e op,
                                        input logic signed [COORD_W-1:0] xs, ys, xe, ye,
                                        input logic [dda_pkg::COLOR_BITS-1:0] col);
    pixel_t idle_px;
    longint steps;
    if (op == dda_pkg::OP_START) begin
      steps            = line_steps(xs, ys, xe, ye);
      inc_x            = fixed_ratio(longint'(xe) - longint'(xs), steps);
      inc_y            = fixed_ratio(longint'(ye) - longint'(ys), steps);
      cur_x            = longint'(xs) * (longint'(1) << FRAC_W);
      cur_y            = longint'(ys) * (longint'(1) << FRAC_W);
      pixels_remaining = steps;
      held_color       = col;
      drawing          = (steps > 0);
      push_pixel(steps == 0);
    end else if (!drawing) begin
      idle_px.addr   = '0;
      idle_px.color  = '0;
      idle_px.status = dda_pkg::STATUS_IDLE;
      idle_px.last   = 1'b0;
      pixel_q.push_back(idle_px);
    end else begin
      cur_x            = cur_x + inc_x;
      cur_y            = cur_y + inc_y;
      pixels_remaining = pixels_remaining - 1;
      if (pixels_remaining == 0) drawing = 1'b0;
      push_pixel(pixels_remaining == 0);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected pixel word, expected none actual addr %h status %h",
                 $time, pixel_address, status);
        errors++;
      end else begin
        want = pixel_q.pop_front();
        if (pixel_address !== want.addr) begin
          $display("%0t: pixel_address expected %h actual %h", $time, want.addr, pixel_address);
          errors++;
        end
        if (pixel_color !== want.color) begin
          $display("%0t: pixel_color expected %h actual %h", $time, want.color, pixel_color);
          errors++;
        end
        if (status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status);
          errors++;
        end
        if (last_pixel !== want.last) begin
          $display("%0t: last_pixel expected %b actual %b", $time, want.last, last_pixel);
          errors++;
        end
      end
    end
  end

  task automatic send_word(input dda_pkg::op_e op,
                           input logic signed [COORD_W-1:0] xs, ys, xe, ye,
                           input logic [dda_pkg::COLOR_BITS-1:0] col);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    x_start    <= xs;
    y_start    <= ys;
    x_end      <= xe;
    y_end      <= ye;
    line_color <= col;
    do @(posedge clk); while (in_stall);
    predict_pixel(op, xs, ys, xe, ye, col);
    sent_words++;
  endtask

  task automatic advance_word();
    send_word(dda_pkg::OP_ADVANCE, COORD_W'($urandom()), COORD_W'($urandom()),
              COORD_W'($urandom()), COORD_W'($urandom()), $urandom());
  endtask

  task automatic draw_line(input logic signed [COORD_W-1:0] xs, ys, xe, ye,
                           input logic [dda_pkg::COLOR_BITS-1:0] col,
                           input int unsigned advances);
    send_word(dda_pkg::OP_START, xs, ys, xe, ye, col);
    repeat (advances) advance_word();
  endtask

  task automatic wait_pixels_drained();
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_frame(input logic [dda_pkg::CFG_BITS-1:0] w, h);
    wait_pixels_drained();
    cfg_we    <= 1'b1;
    cfg_index <= dda_pkg::CFG_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= dda_pkg::CFG_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_we    <= 1'b0;
    frame_w = w;
    frame_h = h;
  endtask

  task automatic test_reset_frame();
    advance_word();
    draw_line(16'sd100, 16'sd200, 16'sd100, 16'sd200, 32'hFFFF_FFFF, 0);
    draw_line(16'sd0, 16'sd0, 16'sd3, 16'sd1, 32'h0000_0000, 3);
    draw_line(16'sd639, 16'sd479, 16'sd636, 16'sd483, 32'h1234_5678, 4);
    draw_line(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 32'hA5A5_5A5A, 2);
    // start over while a line is still in progress
    draw_line(16'sd5, 16'sd5, 16'sd5, 16'sd2, 32'h5A5A_A5A5, 4);
    draw_line(16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, 32'h8000_0001, 1);
  endtask

  task automatic test_frame_extremes();
    set_frame(13'd1, 13'd1);
    draw_line(16'sd0, 16'sd0, 16'sd1, -16'sd1, 32'hC0FF_EE00, 1);
    set_frame(13'd4096, 13'd4096);
    draw_line(16'sd4095, 16'sd0, 16'sd4095, 16'sd0, 32'h0F0F_0F0F, 0);
    // zero width clips everything
    set_frame(13'd0, 13'd480);
    draw_line(16'sd0, 16'sd0, 16'sd2, 16'sd0, 32'hF0F0_F0F0, 0);
    // address wraps past the bus width
    set_frame(13'd8191, 13'd8191);
    draw_line(16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0000_FFFF, 0);
  endtask

  task automatic random_lines(input int unsigned count);
    int unsigned stop_at;
    int unsigned pick;
    longint steps;
    logic signed [COORD_W-1:0] xs, ys, xe, ye;
    stop_at = sent_words + count;
    while (sent_words < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        xs = COORD_W'($urandom_range(int'(frame_w) + 16) - 8);
        ys = COORD_W'($urandom_range(int'(frame_h) + 16) - 8);
        xe = xs + COORD_W'($urandom_range(40) - 20);
        ye = ys + COORD_W'($urandom_range(40) - 20);
        steps = line_steps(xs, ys, xe, ye);
        pick = $urandom_range(99);
        if (pick < 15) begin
          draw_line(xs, ys, xe, ye, $urandom(), $urandom_range(int'(steps)));
        end else if (pick < 35) begin
          draw_line(xs, ys, xe, ye, $urandom(), int'(steps) + $urandom_range(2, 1));
        end else begin
          draw_line(xs, ys, xe, ye, $urandom(), int'(steps));
        end
      end else if (pick < 85) begin
        draw_line(COORD_W'($urandom()), COORD_W'($urandom()), COORD_W'($urandom()),
                  COORD_W'($urandom()), $urandom(), $urandom_range(5));
      end else begin
        advance_word();
      end
    end
  endtask

  task automatic test_random_lines();
    int unsigned idle_pct[3]  = '{36, 61, 0};
    int unsigned block_pct[3] = '{61, 36, 0};
    for (int mode = 0; mode < 3; mode++) begin
      set_frame(dda_pkg::CFG_BITS'($urandom_range(32, 1)),
                dda_pkg::CFG_BITS'($urandom_range(32, 1)));
      send_idle_pct = idle_pct[mode];
      stall_pct     = block_pct[mode];
      random_lines(75);
      set_frame(dda_pkg::CFG_BITS'($urandom_range(4096, 1)),
                dda_pkg::CFG_BITS'($urandom_range(4096, 1)));
      random_lines(75);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_frame();
    test_frame_extremes();
    test_random_lines();
    wait_pixels_drained();
    if (errors == 0 && pixel_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
